### sv/dnv_pkg.sv
// Package for the domain name validator: types, error codes, register
// indexes and the ENUM suffix text.
// Depends on nothing; imported by dnv_step, domain_name_validator_unit, dnv_verdict_pkg and the bench.
package dnv_pkg;

  // Number of trailing bytes compared against the ENUM suffix text.
  localparam int SUFFIX_LEN      = 9;
  localparam int SUFFIX_TEXT_LEN = 9;
  localparam int CHARS_W         = $clog2(SUFFIX_LEN + 1);
  localparam int LABEL_LIMIT     = 63;
  localparam int LABEL_LEN_MAX   = 127;
  localparam int COUNT_MAX       = 255;

  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_N    = 8'h6e;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOW_IDN     = 2'd0,
    CFG_MAX_LABEL_LEN = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_START  = 3'd1,
    ERR_BAD_CHAR   = 3'd2,
    ERR_DOUBLE_DSH = 3'd3,
    ERR_BAD_END    = 3'd4,
    ERR_TOO_LONG   = 3'd5,
    ERR_EMPTY      = 3'd6,
    ERR_ENUM       = 3'd7
  } err_e;

  // Per-name state, carried from one character to the next.
  typedef struct packed {
    logic [6:0]                    label_length;
    logic [7:0]                    previous_char;
    logic                          xn_prefix;
    err_e                          first_error;
    logic [7:0]                    labels_seen;
    logic [1:0]                    single_digit;
    logic                          enum_violation;
    logic [SUFFIX_LEN-1:0][7:0]    tail_chars;
    logic [CHARS_W-1:0]            chars_seen;
  } name_state_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] ch_out;
    logic       label_boundary;
    logic       name_done;
    logic       valid_res;
    err_e       error_code;
    logic [7:0] label_count;
    logic       enum_name;
  } result_t;

  // Byte of "e164.arpa" at a given position.
  function automatic logic [7:0] suffix_byte(input int pos);
    logic [7:0] b;
    unique case (pos)
      0:       b = 8'h65;  // e
      1:       b = 8'h31;  // 1
      2:       b = 8'h36;  // 6
      3:       b = 8'h34;  // 4
      4:       b = 8'h2e;  // .
      5:       b = 8'h61;  // a
      6:       b = 8'h72;  // r
      7:       b = 8'h70;  // p
      8:       b = 8'h61;  // a
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

endpackage

### sv/domain_name_validator_unit.sv
// Top level of the domain name validator: stream ports, configuration
// registers, per-name state and a two-entry result buffer.
// Depends on dnv_pkg and dnv_step.

// The block checks a domain name streamed in one byte per beat, with tlast on
// the final byte, against hostname label rules (start and end characters,
// allowed characters, double dashes outside an IDN "xn-" prefix, label length
// and empty labels) and, for names ending in "e164.arpa", the ENUM rule. Every
// input beat gives exactly one result beat that echoes the byte, marks label
// boundaries in tuser and carries the running first error and label count; on
// the tlast beat the verdict and ENUM flag are valid and the per-name state is
// cleared, so the next name may follow in the very next cycle. The block takes
// one byte per clock cycle while the skid entry is empty: the check of a byte
// is a single combinational step from the per-name state register, and the
// result is registered. A second result register behind the output register
// lets one more beat be taken while downstream stalls. Configuration writes
// are always taken and should only be made between names.
module domain_name_validator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream. tdata: [7:0] ch. tlast: last_char.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  input  logic                          s_axis_tlast,
  // Result stream. tdata: [7:0] ch_out, [8] valid_res, [11:9] error_code,
  // [19:12] label_count, [20] enum_name, [23:21] zero.
  // tuser: label_boundary. tlast: name_done.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dnv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  // Configuration writes: index 0 allow_idn, index 1 max_label_len.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dnv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dnv_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dnv_pkg::*;

  logic        allow_idn_q;
  logic [5:0]  max_label_len_q;

  name_state_t state_q, state_d;
  result_t     result_d;
  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_beat, out_beat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_idn_q     <= 1'b0;
      max_label_len_q <= 6'(LABEL_LIMIT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ALLOW_IDN:     allow_idn_q     <= cfg_data_i[0];
        CFG_MAX_LABEL_LEN: max_label_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dnv_step u_step (
    .state_i         (state_q),
    .ch_i            (s_axis_tdata),
    .last_i          (s_axis_tlast),
    .allow_idn_i     (allow_idn_q),
    .max_label_len_i (max_label_len_q),
    .state_o         (state_d),
    .result_o        (result_d)
  );

  // Per-name state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_beat) begin
      state_q <= state_d;
    end
  end

  // Output register with a skid entry behind it. The skid entry only fills
  // when a beat is accepted while the output register is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_beat || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_beat;
      end
    end else if (in_beat) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_beat || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : result_d;
    end
    if (in_beat && out_valid_q && !out_beat) begin
      skid_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.label_boundary;
  assign m_axis_tlast  = out_q.name_done;
  assign m_axis_tdata  = {3'b000, out_q.enum_name, out_q.label_count,
                          out_q.error_code, out_q.valid_res, out_q.ch_out};

`ifndef ASSERT_OFF
  // The skid entry never holds a beat unless the output register does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  // The end of a name is always a label boundary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("name end without label boundary");

  // A passing verdict never carries an error code and comes only on a name end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && out_q.valid_res) |->
                   (out_q.error_code == ERR_NONE && out_q.name_done))
    else $error("valid verdict with error code or before name end");

  // After the last byte of a name the per-name state starts afresh.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_beat && s_axis_tlast) |=>
                   (state_q.labels_seen == 8'd0 && state_q.first_error == ERR_NONE))
    else $error("per-name state not cleared after name end");
`endif

endmodule

### sv/dnv_step.sv
// Combinational next-state and result logic for one character of a name.
// Depends on dnv_pkg.
module dnv_step (
  input  dnv_pkg::name_state_t state_i,
  input  logic [7:0]           ch_i,
  input  logic                 last_i,
  input  logic                 allow_idn_i,
  input  logic [5:0]           max_label_len_i,
  output dnv_pkg::name_state_t state_o,
  output dnv_pkg::result_t     result_o
);
  import dnv_pkg::*;

  function automatic err_e note_err(input err_e cur, input err_e code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  // Closes the current label: end checks, ENUM bookkeeping, count.
  function automatic name_state_t close_label(input name_state_t s,
                                              input logic [5:0] max_len);
    name_state_t r;
    logic        single;
    r = s;
    if (s.label_length == 7'd0) begin
      r.first_error = note_err(r.first_error, ERR_EMPTY);
    end else begin
      if (!is_alnum(s.previous_char)) begin
        r.first_error = note_err(r.first_error, ERR_BAD_END);
      end
      if ((s.label_length > {1'b0, max_len}) ||
          (s.label_length > 7'(LABEL_LIMIT))) begin
        r.first_error = note_err(r.first_error, ERR_TOO_LONG);
      end
    end
    single = (s.label_length == 7'd1) && is_digit(s.previous_char);
    if ((s.labels_seen >= 8'd2) && !s.single_digit[1]) begin
      r.enum_violation = 1'b1;
    end
    r.single_digit = {s.single_digit[0], single};
    if (s.labels_seen != 8'(COUNT_MAX)) begin
      r.labels_seen = s.labels_seen + 8'd1;
    end
    r.label_length  = '0;
    r.previous_char = '0;
    r.xn_prefix     = 1'b0;
    return r;
  endfunction

  name_state_t s;
  logic        suffix_hit;
  logic        enum_hit;

  always_comb begin
    s = state_i;

    // Shift the byte into the tail window; index SUFFIX_LEN-1 is the newest.
    for (int i = 0; i < SUFFIX_LEN - 1; i++) begin
      s.tail_chars[i] = state_i.tail_chars[i+1];
    end
    s.tail_chars[SUFFIX_LEN-1] = ch_i;
    if (state_i.chars_seen != CHARS_W'(SUFFIX_LEN)) begin
      s.chars_seen = state_i.chars_seen + CHARS_W'(1);
    end

    if (ch_i == CH_DOT) begin
      s = close_label(s, max_label_len_i);
    end else begin
      if (state_i.label_length == 7'd0) begin
        if (!is_alnum(ch_i)) begin
          s.first_error = note_err(s.first_error, ERR_BAD_START);
        end
      end else if (ch_i == CH_DASH) begin
        if ((state_i.previous_char == CH_DASH) &&
            !(allow_idn_i && (state_i.label_length == 7'd3) && state_i.xn_prefix)) begin
          s.first_error = note_err(s.first_error, ERR_DOUBLE_DSH);
        end
      end else if (!is_alnum(ch_i)) begin
        s.first_error = note_err(s.first_error, ERR_BAD_CHAR);
      end

      unique case (state_i.label_length)
        7'd0:    s.xn_prefix = (ch_i == CH_X);
        7'd1:    s.xn_prefix = state_i.xn_prefix && (ch_i == CH_N);
        7'd2:    s.xn_prefix = state_i.xn_prefix && (ch_i == CH_DASH);
        default: s.xn_prefix = 1'b0;
      endcase
      if (state_i.label_length != 7'(LABEL_LEN_MAX)) begin
        s.label_length = state_i.label_length + 7'd1;
      end
      s.previous_char = ch_i;
    end

    // Suffix compare over the updated window, position by position.
    suffix_hit = (s.chars_seen == CHARS_W'(SUFFIX_LEN));
    for (int i = 0; i < SUFFIX_LEN; i++) begin
      if ((SUFFIX_TEXT_LEN - SUFFIX_LEN + i < 0) ||
          (SUFFIX_TEXT_LEN - SUFFIX_LEN + i >= SUFFIX_TEXT_LEN)) begin
        suffix_hit = 1'b0;
      end else if (s.tail_chars[i] != suffix_byte(SUFFIX_TEXT_LEN - SUFFIX_LEN + i)) begin
        suffix_hit = 1'b0;
      end
    end

    enum_hit = 1'b0;
    if (last_i) begin
      s = close_label(s, max_label_len_i);
      enum_hit = suffix_hit;
      if (enum_hit && ((s.labels_seen <= 8'd2) || s.enum_violation)) begin
        s.first_error = note_err(s.first_error, ERR_ENUM);
      end
    end

    result_o.ch_out         = ch_i;
    result_o.label_boundary = last_i || (ch_i == CH_DOT);
    result_o.name_done      = last_i;
    result_o.valid_res      = last_i && (s.first_error == ERR_NONE);
    result_o.error_code     = s.first_error;
    result_o.label_count    = s.labels_seen;
    result_o.enum_name      = enum_hit;

    state_o = last_i ? name_state_t'('0) : s;
  end

endmodule

### verif/dnv_verdict_pkg.sv
// Expected-result store for the domain name validator bench: a bit-exact
// predictor of the per-character hostname and ENUM checks, plus in-order beat comparison.
// Depends on dnv_pkg for the result type, the error codes and the register indexes.
package dnv_verdict_pkg;
  import dnv_pkg::*;

  // Raw text that marks an ENUM name; the newest byte sits in the lowest byte.
  localparam logic [71:0] ENUM_TAIL = "e164.arpa";

  class name_verdict_board;
    logic        allow_idn;
    logic [5:0]  max_len;
    logic [6:0]  lab_len;
    logic [7:0]  prev_ch;
    logic        xn_so_far;
    err_e        first_err;
    logic [7:0]  labels;
    logic [1:0]  single_flags;
    logic        enum_bad;
    logic [71:0] tail_bytes;
    int          tail_cnt;
    result_t     verdict_q[$];
    int          mismatches;
    int          beats;

    function new();
      allow_idn  = 1'b0;
      max_len    = 6'd63;
      mismatches = 0;
      beats      = 0;
      clear_name();
    endfunction

    function bit digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function bit letter_or_digit(logic [7:0] c);
      return digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function void flag_error(err_e code);
      if (first_err == ERR_NONE) first_err = code;
    endfunction

    function void clear_name();
      lab_len      = '0;
      prev_ch      = '0;
      xn_so_far    = 1'b0;
      first_err    = ERR_NONE;
      labels       = '0;
      single_flags = '0;
      enum_bad     = 1'b0;
      tail_bytes   = '0;
      tail_cnt     = 0;
    endfunction

    function void close_label();
      logic single;
      if (lab_len == 0) begin
        flag_error(ERR_EMPTY);
      end else begin
        if (!letter_or_digit(prev_ch)) flag_error(ERR_BAD_END);
        if (lab_len > max_len || lab_len > 7'd63) flag_error(ERR_TOO_LONG);
      end
      single = (lab_len == 1) && digit(prev_ch);
      // Every label but the newest two must be a single digit.
      if (labels >= 2 && !single_flags[1]) enum_bad = 1'b1;
      single_flags = {single_flags[0], single};
      if (labels != 8'hff) labels++;
      lab_len   = '0;
      prev_ch   = '0;
      xn_so_far = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [5:0] value);
      if (idx == CFG_ALLOW_IDN) allow_idn = value[0];
      else if (idx == CFG_MAX_LABEL_LEN) max_len = value;
    endfunction

    // Notes one accepted input beat and queues the result beat it must give.
    function void take_char(logic [7:0] c, logic last);
      result_t want;
      logic    hit;
      hit = 1'b0;
      want.label_boundary = 1'b0;
      tail_bytes = {tail_bytes[63:0], c};
      if (tail_cnt < 9) tail_cnt++;
      if (c == CH_DOT) begin
        close_label();
        want.label_boundary = 1'b1;
      end else begin
        if (lab_len == 0) begin
          if (!letter_or_digit(c)) flag_error(ERR_BAD_START);
        end else if (c == CH_DASH) begin
          if (prev_ch == CH_DASH && !(allow_idn && lab_len == 3 && xn_so_far))
            flag_error(ERR_DOUBLE_DSH);
        end else if (!letter_or_digit(c)) begin
          flag_error(ERR_BAD_CHAR);
        end
        if (lab_len == 0) xn_so_far = (c == CH_X);
        else if (lab_len == 1) xn_so_far = xn_so_far && (c == CH_N);
        else if (lab_len == 2) xn_so_far = xn_so_far && (c == CH_DASH);
        else xn_so_far = 1'b0;
        if (lab_len < 7'd127) lab_len++;
        prev_ch = c;
      end
      if (last) begin
        close_label();
        want.label_boundary = 1'b1;
        hit = (tail_cnt >= 9) && (tail_bytes == ENUM_TAIL);
        if (hit && (labels <= 2 || enum_bad)) flag_error(ERR_ENUM);
      end
      want.ch_out      = c;
      want.name_done   = last;
      want.valid_res   = last && (first_err == ERR_NONE);
      want.error_code  = first_err;
      want.label_count = labels;
      want.enum_name   = hit;
      verdict_q.insert(verdict_q.size(), want);
      if (last) clear_name();
    endfunction

    function void match_beat(result_t seen, logic [2:0] pad);
      result_t want;
      beats++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: result ch=%h arrived with nothing expected", beats, seen.ch_out);
        return;
      end
      want = verdict_q.pop_front();
      if (seen !== want || pad !== 3'b000) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat %0d mismatch, expected / actual:", beats);
          $display("  ch %h / %h  boundary %b / %b  done %b / %b  valid %b / %b",
                   want.ch_out, seen.ch_out, want.label_boundary, seen.label_boundary,
                   want.name_done, seen.name_done, want.valid_res, seen.valid_res);
          $display("  error %0d / %0d  labels %0d / %0d  enum %b / %b  padding %b",
                   want.error_code, seen.error_code, want.label_count, seen.label_count,
                   want.enum_name, seen.enum_name, pad);
        end
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

endpackage

### verif/domain_name_validator_unit_tb.sv
// Top-level bench for domain_name_validator_unit: streams domain names byte by byte
// under random back-pressure and checks every result beat against a predictor.
// Depends on dnv_pkg, dnv_verdict_pkg and the RTL of the block.
module domain_name_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dnv_pkg::*;
  import dnv_verdict_pkg::*;

  // Cycles without any accepted beat on any channel before the run is declared hung.
  // The longest legal quiet stretch is the deliberate receiver hold-off (HOLD_CYCLES).
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 56;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  name_verdict_board board = new();

  // Bytes of the name currently being built and sent.
  logic [7:0] name_bytes[$];
  // Label length limit in force, used to aim label lengths at the boundary.
  logic [5:0] cur_max   = 6'd63;
  int         tx_calm   = 0;
  int         idle_cycles = 0;

  domain_name_validator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle cycles before the next beat on either side. Now and then a side enters a
  // calm stretch of back-to-back beats so that full-rate operation is covered too.
  function automatic int next_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(15, 50);
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 3))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // Mostly short labels; now and then one just below, at or above the limit.
  function automatic int pick_len();
    int n;
    if ($urandom_range(0, 15) == 0) begin
      n = int'(cur_max) + int'($urandom_range(0, 2)) - 1;
      return (n < 1) ? 1 : n;
    end
    return $urandom_range(1, 8);
  endfunction

  // Appends one byte to the name under construction.
  function automatic void put_byte(logic [7:0] b);
    name_bytes.insert(name_bytes.size(), b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // A well-formed label shape: alphanumeric ends, dashes sprinkled inside. Two
  // dashes may land side by side, which exercises the double dash rule.
  function automatic void add_label(int len);
    for (int i = 0; i < len; i++) begin
      if (i == 0 || i == len - 1 || $urandom_range(0, 5) != 0)
        put_byte(pick_alnum());
      else
        put_byte(CH_DASH);
    end
  endfunction

  function automatic void add_host();
    int n;
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      if (k > 0) put_byte(CH_DOT);
      add_label(pick_len());
    end
  endfunction

  // Builds one random name. Most are well formed (plain hosts, ENUM names, IDN
  // labels) so that the deeper rules are reached; the rest are damaged names and
  // raw byte noise.
  function automatic void build_name();
    int kind;
    int n;
    int pos;
    name_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      add_host();
    end else if (kind < 65) begin
      // ENUM: single-digit labels, sometimes a longer one, before the suffix.
      n = $urandom_range(0, 4);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 7) == 0) add_label(pick_len());
        else put_byte(8'h30 + 8'($urandom_range(0, 9)));
        put_byte(CH_DOT);
      end
      if ($urandom_range(0, 9) == 0) put_byte(pick_alnum());
      case ($urandom_range(0, 9))
        8:       add_text("E164.ARPA");
        9:       add_text("e164.arpb");
        default: add_text("e164.arpa");
      endcase
    end else if (kind < 75) begin
      // IDN prefixes, exact and near misses, including upper case.
      case ($urandom_range(0, 5))
        0:       add_text("xn---");
        1:       add_text("Xn--");
        2:       add_text("xn-");
        3:       add_text("xN--");
        default: add_text("xn--");
      endcase
      add_label($urandom_range(1, 6));
      if ($urandom_range(0, 1) == 1) begin
        put_byte(CH_DOT);
        add_label(pick_len());
      end
    end else if (kind < 90) begin
      add_host();
      pos = $urandom_range(0, name_bytes.size() - 1);
      case ($urandom_range(0, 5))
        0: name_bytes.insert(pos, 8'($urandom_range(0, 255)));
        1: put_byte(CH_DOT);
        2: name_bytes.push_front(CH_DOT);
        3: begin
          name_bytes.insert(pos, CH_DOT);
          name_bytes.insert(pos, CH_DOT);
        end
        4: name_bytes.push_front(CH_DASH);
        default: name_bytes[pos] = 8'($urandom_range(0, 255));
      endcase
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // Offers one byte and returns at the edge where it is accepted. tvalid is left
  // high so that a following beat with no gap keeps it high without a glitch.
  task automatic send_beat(input logic [7:0] c, input logic last);
    int gap;
    gap = next_gap(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_char(c, last);
  endtask

  task automatic send_name();
    foreach (name_bytes[i]) send_beat(name_bytes[i], i == name_bytes.size() - 1);
  endtask

  task automatic send_text(input string s);
    name_bytes.delete();
    add_text(s);
    send_name();
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [5:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, value);
  endtask

  // Registers change only between names with the block drained. Every byte gives
  // a result beat, so an empty store of expectations means the block is idle.
  task automatic apply_setting(input logic idn, input logic [5:0] max_len);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    // The upper data bits of allow_idn are don't-care and get random values.
    write_reg(CFG_ALLOW_IDN, {5'($urandom_range(0, 31)), idn});
    write_reg(CFG_MAX_LABEL_LEN, max_len);
    cfg_valid_i <= 1'b0;
    cur_max = max_len;
  endtask

  // Main sequence: reset, a directed set of names under reset values, then random
  // names over six register settings, the extremes among them.
  initial begin : stimulus
    int phase_items;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("a");               // shortest name
    send_text(".");               // lone dot: two empty labels
    send_beat(8'h00, 1'b0);       // byte extremes, bad start then bad character
    send_beat(8'hff, 1'b1);
    send_text("a-");              // final label ending in a dash
    send_text("-b.");             // bad start, then a trailing dot
    send_text("xn--a");           // double dash with IDN disabled
    send_text("1.2.e164.arpa");   // valid ENUM name with two digit labels

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: apply_setting(1'b1, 6'd63);
        2: apply_setting(1'b0, 6'd1);
        3: apply_setting(1'b1, 6'd0);
        4: apply_setting(1'($urandom_range(0, 1)), 6'($urandom_range(2, 62)));
        default: apply_setting(1'b0, 6'd63);
      endcase
      if (phase == 1) begin
        // Enough empty labels to saturate the label count, on an ENUM name.
        name_bytes.delete();
        repeat (256) put_byte(CH_DOT);
        add_text("e164.arpa");
        send_name();
        // A label long enough to saturate the internal length counter.
        name_bytes.delete();
        repeat (130) put_byte(pick_alnum());
        add_text(".b");
        send_name();
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_name();
        send_name();
        phase_items += name_bytes.size();
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give the result register time to show any stray beat.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: a random stall before each beat, and once, after 200 beats, a long
  // hold-off while the sender keeps offering, so that the output buffer fills and
  // the block has to stall its input.
  initial begin : result_sink
    int gap;
    int hold_left;
    int rx_beats;
    int rx_calm;
    bit held;
    gap       = 0;
    hold_left = 0;
    rx_beats  = 0;
    rx_calm   = 0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        rx_beats++;
        gap = next_gap(rx_calm);
      end
      if (!held && rx_beats == 200) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every accepted result beat is unpacked and checked against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.ch_out         = m_axis_tdata[7:0];
      seen.valid_res      = m_axis_tdata[8];
      seen.error_code     = err_e'(m_axis_tdata[11:9]);
      seen.label_count    = m_axis_tdata[19:12];
      seen.enum_name      = m_axis_tdata[20];
      seen.label_boundary = m_axis_tuser;
      seen.name_done      = m_axis_tlast;
      board.match_beat(seen, m_axis_tdata[23:21]);
    end
  end

  // Watchdog: counts cycles in which no channel moves a beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
sv/dnv_pkg.sv
sv/dnv_step.sv
sv/domain_name_validator_unit.sv
verif/dnv_verdict_pkg.sv
verif/domain_name_validator_unit_tb.sv
